@@ rtl/core/usct_pkg.sv @@
// Shared types, constants and arithmetic helpers for the UV sphere cell tessellator.
package usct_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_STACK_COUNT = 2'd0;
    localparam logic [1:0] REG_SLICE_COUNT = 2'd1;
    localparam logic [1:0] REG_RADIUS      = 2'd2;

    localparam int          CNT_W         = 9;
    localparam logic [8:0]  MAX_DIVISIONS = 9'd256;

    // Angle tags, one per division/rotation of an item
    localparam logic [1:0] TAG_PHI0 = 2'd0;
    localparam logic [1:0] TAG_PHI1 = 2'd1;
    localparam logic [1:0] TAG_TH0  = 2'd2;
    localparam logic [1:0] TAG_TH1  = 2'd3;

    // Divider: 44-bit dividend, four quotient bits per stage
    localparam int NUM_W      = 44;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = NUM_W / DIV_STEPS;

    // CORDIC
    localparam int                 CORDIC_STEPS = 16;
    localparam logic signed [32:0] CORDIC_GAIN  = 33'sd652032874;
    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    localparam logic signed [63:0] ONE_Q30  = 64'sd1073741824;
    localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

    // Control that travels with each pipeline entry
    typedef struct packed {
        logic       vld;
        logic [1:0] tag;
        logic       err;
    } t_ctl;

    // Vertex order: bit 0 picks theta, bit 1 picks phi
    function automatic logic [1:0] corner_sel(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd1;
            3'd2:    r = 2'd2;
            3'd3:    r = 2'd1;
            3'd4:    r = 2'd2;
            3'd5:    r = 2'd3;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Corner number within the triangle
    function automatic logic [1:0] corner_num(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0, 3'd3: r = 2'd0;
            3'd1, 3'd4: r = 2'd1;
            3'd2, 3'd5: r = 2'd2;
            default:    r = 2'd0;
        endcase
        return r;
    endfunction

    // Clamp a wide value to [-1, 1] in Q2.30
    function automatic logic signed [31:0] clamp_unit(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > ONE_Q30) begin
            r = ONE_Q30;
        end else if (v < -ONE_Q30) begin
            r = -ONE_Q30;
        end else begin
            r = v;
        end
        return r[31:0];
    endfunction

    // Q2.30 product, rounded half up, clamped
    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [63:0] m;
        logic signed [63:0] p;
        m = a * b;
        p = m + HALF_Q30;
        return clamp_unit(p >>> 30);
    endfunction

    // radius (Q8.8) times unit component, rounded half up
    function automatic logic [16:0] pos_q88(input logic [15:0] rad,
                                            input logic signed [31:0] u);
        logic signed [48:0] m;
        logic signed [63:0] p;
        m = $signed({1'b0, rad}) * u;
        p = 64'(m) + HALF_Q30;
        p = p >>> 30;
        return p[16:0];
    endfunction

    // Q2.30 to Q2.14, rounded half up
    function automatic logic [15:0] nrm_q14(input logic signed [31:0] u);
        logic signed [32:0] p;
        p = 33'(u) + 33'sd32768;
        p = p >>> 16;
        return p[15:0];
    endfunction

endpackage

@@ rtl/core/usct_div.sv @@
// Pipelined restoring divider producing the 32-bit angle phase.
module usct_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  usct_pkg::t_ctl                  i_ctl,
    input  logic [usct_pkg::NUM_W-1:0]      i_num,
    input  logic [usct_pkg::CNT_W-1:0]      i_den,
    output usct_pkg::t_ctl                  o_ctl,
    output logic [31:0]                     o_quo
);

    usct_pkg::t_ctl                 r_ctl [usct_pkg::DIV_STAGES];
    logic [usct_pkg::CNT_W-1:0]     r_rem [usct_pkg::DIV_STAGES];
    logic [usct_pkg::NUM_W-1:0]     r_num [usct_pkg::DIV_STAGES];
    logic [usct_pkg::CNT_W-1:0]     r_den [usct_pkg::DIV_STAGES];

    usct_pkg::t_ctl                 s_ctl [usct_pkg::DIV_STAGES];
    logic [usct_pkg::CNT_W-1:0]     s_rem [usct_pkg::DIV_STAGES];
    logic [usct_pkg::NUM_W-1:0]     s_num [usct_pkg::DIV_STAGES];
    logic [usct_pkg::CNT_W-1:0]     s_den [usct_pkg::DIV_STAGES];
    logic [usct_pkg::CNT_W-1:0]     n_rem [usct_pkg::DIV_STAGES];
    logic [usct_pkg::NUM_W-1:0]     n_num [usct_pkg::DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < usct_pkg::DIV_STAGES; s++) begin : g_stage
            // stage source
            if (s == 0) begin : g_first
                assign s_ctl[s] = i_ctl;
                assign s_rem[s] = '0;
                assign s_num[s] = i_num;
                assign s_den[s] = i_den;
            end else begin : g_next
                assign s_ctl[s] = r_ctl[s-1];
                assign s_rem[s] = r_rem[s-1];
                assign s_num[s] = r_num[s-1];
                assign s_den[s] = r_den[s-1];
            end

            // four shift/compare/subtract steps
            always_comb begin
                logic [usct_pkg::CNT_W:0]   rem2;
                logic [usct_pkg::CNT_W-1:0] rem;
                logic [usct_pkg::NUM_W-1:0] num;
                rem = s_rem[s];
                num = s_num[s];
                for (int i = 0; i < usct_pkg::DIV_STEPS; i++) begin
                    rem2 = {rem, num[usct_pkg::NUM_W-1]};
                    num  = num << 1;
                    if (rem2 >= {1'b0, s_den[s]}) begin
                        rem2   = rem2 - {1'b0, s_den[s]};
                        num[0] = 1'b1;
                    end
                    rem = rem2[usct_pkg::CNT_W-1:0];
                end
                n_rem[s] = rem;
                n_num[s] = num;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctl[s] <= '0;
                end else begin
                    r_ctl[s] <= s_ctl[s];
                end
                r_rem[s] <= n_rem[s];
                r_num[s] <= n_num[s];
                r_den[s] <= s_den[s];
            end
        end
    endgenerate

    assign o_ctl = r_ctl[usct_pkg::DIV_STAGES-1];
    assign o_quo = r_num[usct_pkg::DIV_STAGES-1][31:0];

endmodule

@@ rtl/core/usct_cordic.sv @@
// Sixteen-stage rotation-mode CORDIC over a quarter-turn phase.
module usct_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  usct_pkg::t_ctl     i_ctl,
    input  logic [31:0]        i_phase,
    output usct_pkg::t_ctl     o_ctl,
    output logic signed [32:0] o_x,
    output logic signed [32:0] o_y,
    output logic [1:0]         o_quad
);

    usct_pkg::t_ctl     r_ctl  [usct_pkg::CORDIC_STEPS];
    logic signed [32:0] r_x    [usct_pkg::CORDIC_STEPS];
    logic signed [32:0] r_y    [usct_pkg::CORDIC_STEPS];
    logic signed [32:0] r_z    [usct_pkg::CORDIC_STEPS];
    logic [1:0]         r_quad [usct_pkg::CORDIC_STEPS];

    usct_pkg::t_ctl     s_ctl  [usct_pkg::CORDIC_STEPS];
    logic signed [32:0] s_x    [usct_pkg::CORDIC_STEPS];
    logic signed [32:0] s_y    [usct_pkg::CORDIC_STEPS];
    logic signed [32:0] s_z    [usct_pkg::CORDIC_STEPS];
    logic [1:0]         s_quad [usct_pkg::CORDIC_STEPS];
    logic signed [32:0] n_x    [usct_pkg::CORDIC_STEPS];
    logic signed [32:0] n_y    [usct_pkg::CORDIC_STEPS];
    logic signed [32:0] n_z    [usct_pkg::CORDIC_STEPS];

    genvar s;
    generate
        for (s = 0; s < usct_pkg::CORDIC_STEPS; s++) begin : g_stage
            // stage source
            if (s == 0) begin : g_first
                assign s_ctl[s]  = i_ctl;
                assign s_x[s]    = usct_pkg::CORDIC_GAIN;
                assign s_y[s]    = '0;
                assign s_z[s]    = $signed({3'b000, i_phase[29:0]});
                assign s_quad[s] = i_phase[31:30];
            end else begin : g_next
                assign s_ctl[s]  = r_ctl[s-1];
                assign s_x[s]    = r_x[s-1];
                assign s_y[s]    = r_y[s-1];
                assign s_z[s]    = r_z[s-1];
                assign s_quad[s] = r_quad[s-1];
            end

            // one micro-rotation
            always_comb begin
                logic signed [32:0] xs;
                logic signed [32:0] ys;
                logic signed [32:0] at;
                xs = s_x[s] >>> s;
                ys = s_y[s] >>> s;
                at = $signed({1'b0, usct_pkg::ATAN_TURN[s]});
                if (!s_z[s][32]) begin
                    n_x[s] = s_x[s] - ys;
                    n_y[s] = s_y[s] + xs;
                    n_z[s] = s_z[s] - at;
                end else begin
                    n_x[s] = s_x[s] + ys;
                    n_y[s] = s_y[s] - xs;
                    n_z[s] = s_z[s] + at;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctl[s] <= '0;
                end else begin
                    r_ctl[s] <= s_ctl[s];
                end
                r_x[s]    <= n_x[s];
                r_y[s]    <= n_y[s];
                r_z[s]    <= n_z[s];
                r_quad[s] <= s_quad[s];
            end
        end
    endgenerate

    assign o_ctl  = r_ctl[usct_pkg::CORDIC_STEPS-1];
    assign o_x    = r_x[usct_pkg::CORDIC_STEPS-1];
    assign o_y    = r_y[usct_pkg::CORDIC_STEPS-1];
    assign o_quad = r_quad[usct_pkg::CORDIC_STEPS-1];

endmodule

@@ rtl/core/usct_vertex.sv @@
// Collects an item's four angles, then emits six vertices or one error result via two product stages.
module usct_vertex (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  usct_pkg::t_ctl     i_ctl,
    input  logic signed [32:0] i_x,
    input  logic signed [32:0] i_y,
    input  logic [1:0]         i_quad,
    input  logic [15:0]        i_radius,
    output logic               o_valid,
    output logic [16:0]        o_pos_x,
    output logic [16:0]        o_pos_y,
    output logic [16:0]        o_pos_z,
    output logic [15:0]        o_norm_x,
    output logic [15:0]        o_norm_y,
    output logic [15:0]        o_norm_z,
    output logic               o_triangle_sel,
    output logic [1:0]         o_corner,
    output logic               o_index_error,
    output logic               o_last
);

    logic signed [32:0] cs_c;
    logic signed [32:0] cs_s;

    // quadrant restore
    always_comb begin
        case (i_quad)
            2'd0:    begin cs_c = i_x;  cs_s = i_y;  end
            2'd1:    begin cs_c = -i_y; cs_s = i_x;  end
            2'd2:    begin cs_c = -i_x; cs_s = -i_y; end
            2'd3:    begin cs_c = i_y;  cs_s = -i_x; end
            default: begin cs_c = i_x;  cs_s = i_y;  end
        endcase
    end

    // collect bank, then snapshot bank on the last angle
    logic signed [31:0] r_c  [4];
    logic signed [31:0] r_s  [4];
    logic signed [31:0] r_bc [4];
    logic signed [31:0] r_bs [4];
    logic               r_seq_act;
    logic [2:0]         r_seq_k;
    logic               r_seq_err;

    logic last_angle;
    assign last_angle = i_ctl.vld && (i_ctl.tag == usct_pkg::TAG_TH1);

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_c[i_ctl.tag] <= cs_c[31:0];
            r_s[i_ctl.tag] <= cs_s[31:0];
        end
        if (last_angle) begin
            for (int i = 0; i < 3; i++) begin
                r_bc[i] <= r_c[i];
                r_bs[i] <= r_s[i];
            end
            r_bc[3]   <= cs_c[31:0];
            r_bs[3]   <= cs_s[31:0];
            r_seq_err <= i_ctl.err;
        end
    end

    // vertex sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_act <= 1'b0;
            r_seq_k   <= '0;
        end else if (last_angle) begin
            r_seq_act <= 1'b1;
            r_seq_k   <= '0;
        end else if (r_seq_act) begin
            if (r_seq_err || r_seq_k == 3'd5) begin
                r_seq_act <= 1'b0;
            end
            r_seq_k <= r_seq_k + 3'd1;
        end
    end

    // first product stage
    logic [1:0]         sel;
    logic signed [31:0] cth;
    logic signed [31:0] sth;
    logic signed [31:0] cph;
    logic signed [31:0] sph;
    assign sel = usct_pkg::corner_sel(r_seq_k);
    assign cth = r_bc[{1'b1, sel[0]}];
    assign sth = r_bs[{1'b1, sel[0]}];
    assign cph = r_bc[{1'b0, sel[1]}];
    assign sph = r_bs[{1'b0, sel[1]}];

    logic               r_m_vld;
    logic               r_m_err;
    logic [2:0]         r_m_k;
    logic signed [31:0] r_u0;
    logic signed [31:0] r_u1;
    logic signed [31:0] r_u2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= r_seq_act;
        end
        r_m_err <= r_seq_err;
        r_m_k   <= r_seq_k;
        r_u0    <= usct_pkg::mul_q30(cth, sph);
        r_u1    <= usct_pkg::mul_q30(sth, sph);
        r_u2    <= usct_pkg::clamp_unit(64'(cph));
    end

    // output stage: scale and round
    logic        r_valid;
    logic [16:0] r_pos_x;
    logic [16:0] r_pos_y;
    logic [16:0] r_pos_z;
    logic [15:0] r_norm_x;
    logic [15:0] r_norm_y;
    logic [15:0] r_norm_z;
    logic        r_tri;
    logic [1:0]  r_corner;
    logic        r_err;
    logic        r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_m_vld;
        end
        if (r_m_err) begin
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_pos_z  <= '0;
            r_norm_x <= '0;
            r_norm_y <= '0;
            r_norm_z <= '0;
            r_tri    <= 1'b0;
            r_corner <= '0;
            r_err    <= 1'b1;
            r_last   <= 1'b1;
        end else begin
            r_pos_x  <= usct_pkg::pos_q88(i_radius, r_u0);
            r_pos_y  <= usct_pkg::pos_q88(i_radius, r_u1);
            r_pos_z  <= usct_pkg::pos_q88(i_radius, r_u2);
            r_norm_x <= usct_pkg::nrm_q14(r_u0);
            r_norm_y <= usct_pkg::nrm_q14(r_u1);
            r_norm_z <= usct_pkg::nrm_q14(r_u2);
            r_tri    <= (r_m_k >= 3'd3);
            r_corner <= usct_pkg::corner_num(r_m_k);
            r_err    <= 1'b0;
            r_last   <= (r_m_k == 3'd5);
        end
    end

    assign o_valid        = r_valid;
    assign o_pos_x        = r_pos_x;
    assign o_pos_y        = r_pos_y;
    assign o_pos_z        = r_pos_z;
    assign o_norm_x       = r_norm_x;
    assign o_norm_y       = r_norm_y;
    assign o_norm_z       = r_norm_z;
    assign o_triangle_sel = r_tri;
    assign o_corner       = r_corner;
    assign o_index_error  = r_err;
    assign o_last         = r_last;

endmodule

@@ rtl/core/uv_sphere_cell_tessellator_top.sv @@
// Top level of the UV sphere cell tessellator: config registers, angle feeder, pipeline.
//
// Usage: raise start with a cell's stack and slice index; the item is taken at a
// clock edge where start is high and busy is low. busy then stays high until the feed
// counter (r_cnt) wraps back to zero, and no new cell is taken while it is high.
// Each item is cut into four angle jobs (two latitudes, two longitudes) that go
// one per cycle through an 11-stage divider and a 16-stage CORDIC, then six
// vertices leave through two product stages, one per cycle, marked by o_valid.
// The first vertex passes the feed counter, the divider and CORDIC stages and the
// snapshot bank, then the two product stages. An out-of-range cell gives one result with
// o_index_error and o_last set, in the slot of the first vertex.
// The sink cannot stall; results are shown for exactly one cycle.
// Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once; the user must
// make them only while no item is in flight; the block does not enforce it. Reset clears
// the pipeline valid bits and loads stack and slice counts of 25 and a radius of 1.0.
module uv_sphere_cell_tessellator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_stack_index,
    input  logic [7:0]  i_slice_index,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [16:0] o_pos_x,
    output logic [16:0] o_pos_y,
    output logic [16:0] o_pos_z,
    output logic [15:0] o_norm_x,
    output logic [15:0] o_norm_y,
    output logic [15:0] o_norm_z,
    output logic        o_triangle_sel,
    output logic [1:0]  o_corner,
    output logic        o_index_error,
    output logic        o_last
);

    localparam logic [2:0] FEED_LAST = 3'd5;

    // configuration registers
    logic [8:0]  r_stack_count;
    logic [8:0]  r_slice_count;
    logic [15:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_count <= 9'd25;
            r_slice_count <= 9'd25;
            r_radius      <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                usct_pkg::REG_STACK_COUNT: r_stack_count <= i_cfg_data[8:0];
                usct_pkg::REG_SLICE_COUNT: r_slice_count <= i_cfg_data[8:0];
                usct_pkg::REG_RADIUS:      r_radius      <= i_cfg_data;
                default:                   ;
            endcase
        end
    end

    // effective counts
    logic [8:0] ns;
    logic [8:0] nl;
    assign ns = (r_stack_count > usct_pkg::MAX_DIVISIONS) ? usct_pkg::MAX_DIVISIONS
                                                          : r_stack_count;
    assign nl = (r_slice_count > usct_pkg::MAX_DIVISIONS) ? usct_pkg::MAX_DIVISIONS
                                                          : r_slice_count;

    // item accept and feed sequencing
    logic       accept;
    logic [2:0] r_cnt;
    logic [7:0] r_si;
    logic [7:0] r_sj;
    logic       r_err;

    assign accept = start && !busy;
    assign busy   = (r_cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= 3'd1;
        end else if (r_cnt != 3'd0) begin
            r_cnt <= (r_cnt == FEED_LAST) ? 3'd0 : r_cnt + 3'd1;
        end
        if (accept) begin
            r_si  <= i_stack_index;
            r_sj  <= i_slice_index;
            r_err <= ({1'b0, i_stack_index} >= ns) || ({1'b0, i_slice_index} >= nl);
        end
    end

    // angle job: dividend and divisor
    usct_pkg::t_ctl             feed_ctl;
    logic [1:0]                 feed_tag;
    logic [8:0]                 feed_idx;
    logic [usct_pkg::NUM_W-1:0] feed_num;
    logic [8:0]                 feed_den;

    assign feed_tag = 2'(r_cnt - 3'd1);

    always_comb begin
        if (feed_tag == usct_pkg::TAG_TH0 || feed_tag == usct_pkg::TAG_TH1) begin
            feed_idx = {1'b0, r_sj} + {8'd0, feed_tag[0]};
            feed_num = (usct_pkg::NUM_W'(feed_idx) << 32) + usct_pkg::NUM_W'(nl >> 1);
            feed_den = nl;
        end else begin
            feed_idx = {1'b0, r_si} + {8'd0, feed_tag[0]};
            feed_num = (usct_pkg::NUM_W'(feed_idx) << 31) + usct_pkg::NUM_W'(ns >> 1);
            feed_den = ns;
        end
        feed_ctl.vld = (r_cnt >= 3'd1) && (r_cnt <= 3'd4);
        feed_ctl.tag = feed_tag;
        feed_ctl.err = r_err;
    end

    // divider
    usct_pkg::t_ctl div_ctl;
    logic [31:0]    div_quo;

    usct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (feed_ctl),
        .i_num   (feed_num),
        .i_den   (feed_den),
        .o_ctl   (div_ctl),
        .o_quo   (div_quo)
    );

    // sine and cosine
    usct_pkg::t_ctl     cor_ctl;
    logic signed [32:0] cor_x;
    logic signed [32:0] cor_y;
    logic [1:0]         cor_quad;

    usct_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_phase (div_quo),
        .o_ctl   (cor_ctl),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_quad  (cor_quad)
    );

    // vertex assembly
    usct_vertex u_vertex (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (cor_ctl),
        .i_x            (cor_x),
        .i_y            (cor_y),
        .i_quad         (cor_quad),
        .i_radius       (r_radius),
        .o_valid        (o_valid),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_norm_x       (o_norm_x),
        .o_norm_y       (o_norm_y),
        .o_norm_z       (o_norm_z),
        .o_triangle_sel (o_triangle_sel),
        .o_corner       (o_corner),
        .o_index_error  (o_index_error),
        .o_last         (o_last)
    );

endmodule

@@ test/uv_sphere_cell_tessellator_top_tb.sv @@
// Testbench for the UV sphere cell tessellator: directed and random cells against a vertex predictor.
`timescale 1ns / 100ps

module uv_sphere_cell_tessellator_top_tb;

    localparam int DRAIN_CYCLES = 60;

    // One vertex result as seen on the output ports
    typedef struct packed {
        logic [16:0] pos_x;
        logic [16:0] pos_y;
        logic [16:0] pos_z;
        logic [15:0] norm_x;
        logic [15:0] norm_y;
        logic [15:0] norm_z;
        logic        tri_sel;
        logic [1:0]  corner;
        logic        idx_err;
        logic        last;
    } t_vertex;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  i_stack_index;
    logic [7:0]  i_slice_index;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic [16:0] o_pos_x;
    logic [16:0] o_pos_y;
    logic [16:0] o_pos_z;
    logic [15:0] o_norm_x;
    logic [15:0] o_norm_y;
    logic [15:0] o_norm_z;
    logic        o_triangle_sel;
    logic [1:0]  o_corner;
    logic        o_index_error;
    logic        o_last;

    // Shadow copy of the configuration
    logic [8:0]  cfg_stacks;
    logic [8:0]  cfg_slices;
    logic [15:0] cfg_radius;

    t_vertex vertex_q[$];
    int      err_count;
    int      burst_left;

    uv_sphere_cell_tessellator_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_stack_index  (i_stack_index),
        .i_slice_index  (i_slice_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_norm_x       (o_norm_x),
        .o_norm_y       (o_norm_y),
        .o_norm_z       (o_norm_z),
        .o_triangle_sel (o_triangle_sel),
        .o_corner       (o_corner),
        .o_index_error  (o_index_error),
        .o_last         (o_last)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Arithmetic shift right, rounding toward minus infinity
    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint sat_unit(input longint v);
        if (v > 64'sd1073741824) return 64'sd1073741824;
        if (v < -64'sd1073741824) return -64'sd1073741824;
        return v;
    endfunction

    // Sine and cosine of a 32-bit turn phase, Q2.30
    task automatic sin_cos(input logic [31:0] phase, output longint c, output longint s);
        longint x, y, z, xs, ys;
        x = 652032874;
        y = 0;
        z = longint'(phase[29:0]);
        for (int i = 0; i < 16; i++) begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - longint'(usct_pkg::ATAN_TURN[i]);
            end else begin
                x = x + ys; y = y - xs; z = z + longint'(usct_pkg::ATAN_TURN[i]);
            end
        end
        case (phase[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    // Expected vertices of one cell
    task automatic predict_cell(input logic [7:0] si, input logic [7:0] sj);
        longint ns, nl, pp, tp, pv, nv;
        longint cph[2], sph[2], cth[2], sth[2], u[3];
        int t, p;
        logic [1:0] sel;
        t_vertex v;
        ns = (cfg_stacks > 256) ? 256 : cfg_stacks;
        nl = (cfg_slices > 256) ? 256 : cfg_slices;
        v = '0;
        if (si >= ns || sj >= nl) begin
            v.idx_err = 1'b1;
            v.last = 1'b1;
            vertex_q.push_back(v);
        end else begin
            for (int k = 0; k < 2; k++) begin
                pp = (((longint'(si) + k) <<< 31) + ns / 2) / ns;
                tp = (((longint'(sj) + k) <<< 32) + nl / 2) / nl;
                sin_cos(pp[31:0], cph[k], sph[k]);
                sin_cos(tp[31:0], cth[k], sth[k]);
            end
            for (int k = 0; k < 6; k++) begin
                sel = usct_pkg::corner_sel(k[2:0]);
                t = sel[0];
                p = sel[1];
                u[0] = sat_unit(shr_floor(cth[t] * sph[p] + (64'sd1 <<< 29), 30));
                u[1] = sat_unit(shr_floor(sth[t] * sph[p] + (64'sd1 <<< 29), 30));
                u[2] = sat_unit(cph[p]);
                pv = shr_floor(longint'(cfg_radius) * u[0] + (64'sd1 <<< 29), 30);
                v.pos_x = pv[16:0];
                pv = shr_floor(longint'(cfg_radius) * u[1] + (64'sd1 <<< 29), 30);
                v.pos_y = pv[16:0];
                pv = shr_floor(longint'(cfg_radius) * u[2] + (64'sd1 <<< 29), 30);
                v.pos_z = pv[16:0];
                nv = shr_floor(u[0] + 32768, 16);
                v.norm_x = nv[15:0];
                nv = shr_floor(u[1] + 32768, 16);
                v.norm_y = nv[15:0];
                nv = shr_floor(u[2] + 32768, 16);
                v.norm_z = nv[15:0];
                v.tri_sel = (k >= 3);
                v.corner = 2'(k % 3);
                v.idx_err = 1'b0;
                v.last = (k == 5);
                vertex_q.push_back(v);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Vertex checker, sampled at the rising edge
    always @(posedge i_clk) begin
        t_vertex exp_v;
        if (i_rst_n && o_valid) begin
            if (vertex_q.size() == 0) begin
                report_mismatch("unexpected vertex", 0, 0);
            end else begin
                exp_v = vertex_q.pop_front();
                if (o_pos_x !== exp_v.pos_x) report_mismatch("pos_x", o_pos_x, exp_v.pos_x);
                if (o_pos_y !== exp_v.pos_y) report_mismatch("pos_y", o_pos_y, exp_v.pos_y);
                if (o_pos_z !== exp_v.pos_z) report_mismatch("pos_z", o_pos_z, exp_v.pos_z);
                if (o_norm_x !== exp_v.norm_x) report_mismatch("norm_x", o_norm_x, exp_v.norm_x);
                if (o_norm_y !== exp_v.norm_y) report_mismatch("norm_y", o_norm_y, exp_v.norm_y);
                if (o_norm_z !== exp_v.norm_z) report_mismatch("norm_z", o_norm_z, exp_v.norm_z);
                if (o_triangle_sel !== exp_v.tri_sel)
                    report_mismatch("triangle_sel", o_triangle_sel, exp_v.tri_sel);
                if (o_corner !== exp_v.corner) report_mismatch("corner", o_corner, exp_v.corner);
                if (o_index_error !== exp_v.idx_err)
                    report_mismatch("index_error", o_index_error, exp_v.idx_err);
                if (o_last !== exp_v.last) report_mismatch("last", o_last, exp_v.last);
            end
        end
    end

    // Wait out the pipeline, then a margin for error-only cells
    task automatic wait_idle();
        while (vertex_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            usct_pkg::REG_STACK_COUNT: cfg_stacks = data[8:0];
            usct_pkg::REG_SLICE_COUNT: cfg_slices = data[8:0];
            usct_pkg::REG_RADIUS:      cfg_radius = data;
            default: ;
        endcase
    endtask

    task automatic set_grid(input int stacks, input int slices, input int rad);
        wait_idle();
        write_reg(usct_pkg::REG_STACK_COUNT, 16'(stacks));
        write_reg(usct_pkg::REG_SLICE_COUNT, 16'(slices));
        write_reg(usct_pkg::REG_RADIUS, 16'(rad));
    endtask

    // Send one cell; random gaps between bursts when asked
    task automatic send_cell(input logic [7:0] si, input logic [7:0] sj, input bit gaps);
        if (gaps) begin
            if (burst_left == 0) begin
                repeat ($urandom_range(0, 12)) @(negedge i_clk);
                burst_left = $urandom_range(1, 10);
            end
            burst_left--;
        end
        start = 1'b1;
        i_stack_index = si;
        i_slice_index = sj;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_cell(si, sj);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic test_reset_grid();
        send_cell(8'd0, 8'd0, 1'b0);
        send_cell(8'd24, 8'd24, 1'b0);
        send_cell(8'd12, 8'd7, 1'b0);
        send_cell(8'd25, 8'd0, 1'b0);
        send_cell(8'd0, 8'd25, 1'b0);
        send_cell(8'd255, 8'd255, 1'b0);
    endtask

    task automatic test_extremes();
        set_grid(256, 256, 16'hFFFF);
        send_cell(8'd0, 8'd0, 1'b0);
        send_cell(8'd255, 8'd255, 1'b0);
        send_cell(8'hAA, 8'h55, 1'b0);
        send_cell(8'h55, 8'hAA, 1'b0);
        set_grid(511, 300, 0);
        send_cell(8'd255, 8'd0, 1'b0);
        send_cell(8'd128, 8'd255, 1'b0);
        set_grid(0, 4, 256);
        send_cell(8'd0, 8'd0, 1'b0);
        set_grid(1, 1, 16'h8000);
        send_cell(8'd0, 8'd0, 1'b0);
        send_cell(8'd1, 8'd0, 1'b0);
        set_grid(2, 3, 384);
        send_cell(8'd1, 8'd2, 1'b0);
        wait_idle();
        write_reg(2'd3, 16'hFFFF);
        send_cell(8'd0, 8'd1, 1'b0);
    endtask

    task automatic test_random_cells();
        int ns, nl;
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_grid(25, 25, 256);
                1: set_grid(256, 256, $urandom_range(0, 65535));
                2: set_grid($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(0, 65535));
                3: set_grid($urandom_range(257, 511), $urandom_range(257, 511), 16'hFFFF);
                4: set_grid($urandom_range(1, 256), $urandom_range(1, 256), $urandom_range(0, 65535));
                5: set_grid(4, 256, 1);
                default: set_grid($urandom_range(1, 256), 2, $urandom_range(0, 65535));
            endcase
            ns = (cfg_stacks > 256) ? 256 : cfg_stacks;
            nl = (cfg_slices > 256) ? 256 : cfg_slices;
            for (int n = 0; n < 50; n++) begin
                // mostly in-range cells, some anywhere
                if ($urandom_range(0, 9) < 8)
                    send_cell(8'($urandom_range(0, ns - 1)), 8'($urandom_range(0, nl - 1)), 1'b1);
                else
                    send_cell(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
                if (n == 25) wait_idle();
            end
        end
    endtask

    initial begin
        err_count = 0;
        burst_left = 0;
        start = 1'b0;
        i_stack_index = '0;
        i_slice_index = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        cfg_stacks = 9'd25;
        cfg_slices = 9'd25;
        cfg_radius = 16'd256;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_grid();
        test_extremes();
        test_random_cells();
        wait_idle();
        if (err_count == 0)
            $display("uv_sphere_cell_tessellator_top_tb: clean");
        else
            $display("uv_sphere_cell_tessellator_top_tb: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("uv_sphere_cell_tessellator_top_tb: errors");
        $finish;
    end

endmodule

@@ uv_sphere_cell_tessellator_top.f @@
rtl/core/usct_pkg.sv
rtl/core/usct_div.sv
rtl/core/usct_cordic.sv
rtl/core/usct_vertex.sv
rtl/core/uv_sphere_cell_tessellator_top.sv
test/uv_sphere_cell_tessellator_top_tb.sv
